// ===== src/smm_pkg.sv =====
// Shared types, codes and field widths for the scaled matrix multiply block.
package smm_pkg;

  localparam int ELEM_W      = 16;
  localparam int FIELD_IDX_W = 6;
  localparam int DIM_REG_W   = 7;
  localparam int Y_W         = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_LOAD_C = 2'd2;
  localparam logic [1:0] REQ_READ_Y = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_M_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_N_COLS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K_DEPTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_A     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_B     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE = 3'd7;

  typedef struct packed {
    logic [DIM_REG_W-1:0]     m_rows;
    logic [DIM_REG_W-1:0]     n_cols;
    logic [DIM_REG_W-1:0]     k_depth;
    logic                     trans_a;
    logic                     trans_b;
    logic signed [ELEM_W-1:0] alpha;
    logic signed [ELEM_W-1:0] beta;
    logic                     bias_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [FIELD_IDX_W-1:0]   row;
    logic [FIELD_IDX_W-1:0]   col;
    logic signed [ELEM_W-1:0] value;
    logic                     ok;
  } cmd_t;

endpackage

// ===== src/smm_if.sv =====
// Handshake channels of the block: request, response and configuration write.
interface smm_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               req_type;
  logic [smm_pkg::FIELD_IDX_W-1:0]          row_index;
  logic [smm_pkg::FIELD_IDX_W-1:0]          col_index;
  logic signed [smm_pkg::ELEM_W-1:0]        elem_value;

  modport source (output valid, req_type, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, req_type, row_index, col_index, elem_value, output ready);
endinterface

interface smm_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [smm_pkg::Y_W-1:0]           y_value;
  logic [smm_pkg::FIELD_IDX_W-1:0]          out_row;
  logic [smm_pkg::FIELD_IDX_W-1:0]          out_col;
  logic                                     in_range;

  modport source (output valid, y_value, out_row, out_col, in_range, input ready);
  modport sink   (input valid, y_value, out_row, out_col, in_range, output ready);
endinterface

interface smm_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [smm_pkg::CFG_IDX_W-1:0]            index;
  logic [smm_pkg::ELEM_W-1:0]               data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/scaled_matrix_multiply.sv =====
// Top level of the scaled matrix multiply block: front end, command queue, back end.
// Computes Y = alpha*op(A)*op(B) + beta*C (beta*C only when bias_enable is set) on Q8.8
// data held in three on-chip stores of MAX_DIM x MAX_DIM entries. Requests pass through a
// four-entry queue, so the request channel keeps accepting while the back end works or a
// result waits to be taken, until the queue is full. A read of Y walks the inner dimension
// one product per cycle through the single read port of the A and B stores and one
// multiplier. Stores come up undefined after reset; read only entries that were loaded.
module scaled_matrix_multiply #(
  parameter int MAX_DIM = 64
) (
  input  logic      clk,
  input  logic      rst,
  smm_req_if.sink   req,
  smm_rsp_if.source rsp,
  smm_cfg_if.sink   cfg
);

  smm_pkg::cfg_t cfg_q;
  smm_pkg::cmd_t push_cmd;
  smm_pkg::cmd_t head;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  smm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .queue_full (full),
    .push       (push),
    .push_cmd   (push_cmd),
    .cfg_q      (cfg_q)
  );

  smm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  smm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg_q (cfg_q),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

// ===== src/smm_front.sv =====
// Front end: configuration registers, request range checks and queue push.
module smm_front #(
  parameter int MAX_DIM = 64
) (
  input  logic                clk,
  input  logic                rst,
  smm_req_if.sink             req,
  smm_cfg_if.sink             cfg,
  input  logic                queue_full,
  output logic                push,
  output smm_pkg::cmd_t       push_cmd,
  output smm_pkg::cfg_t       cfg_q
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > smm_pkg::DIM_REG_W) ? DIM_W : smm_pkg::DIM_REG_W;
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);

  logic [CMP_W-1:0] m_eff;
  logic [CMP_W-1:0] n_eff;
  logic [CMP_W-1:0] row_c;
  logic [CMP_W-1:0] col_c;
  logic             in_store;
  logic             in_dims;
  logic             is_read;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.m_rows      <= smm_pkg::DIM_REG_W'(64);
      cfg_q.n_cols      <= smm_pkg::DIM_REG_W'(64);
      cfg_q.k_depth     <= smm_pkg::DIM_REG_W'(64);
      cfg_q.trans_a     <= 1'b0;
      cfg_q.trans_b     <= 1'b0;
      cfg_q.alpha       <= smm_pkg::ELEM_W'(256);
      cfg_q.beta        <= '0;
      cfg_q.bias_enable <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        smm_pkg::CFG_M_ROWS:      cfg_q.m_rows      <= cfg.data[smm_pkg::DIM_REG_W-1:0];
        smm_pkg::CFG_N_COLS:      cfg_q.n_cols      <= cfg.data[smm_pkg::DIM_REG_W-1:0];
        smm_pkg::CFG_K_DEPTH:     cfg_q.k_depth     <= cfg.data[smm_pkg::DIM_REG_W-1:0];
        smm_pkg::CFG_TRANS_A:     cfg_q.trans_a     <= cfg.data[0];
        smm_pkg::CFG_TRANS_B:     cfg_q.trans_b     <= cfg.data[0];
        smm_pkg::CFG_ALPHA:       cfg_q.alpha       <= cfg.data;
        smm_pkg::CFG_BETA:        cfg_q.beta        <= cfg.data;
        smm_pkg::CFG_BIAS_ENABLE: cfg_q.bias_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Dimensions above the store size act as the store size.
  assign m_eff = (CMP_W'(cfg_q.m_rows) > DIM_MAX) ? DIM_MAX : CMP_W'(cfg_q.m_rows);
  assign n_eff = (CMP_W'(cfg_q.n_cols) > DIM_MAX) ? DIM_MAX : CMP_W'(cfg_q.n_cols);
  assign row_c = CMP_W'(req.row_index);
  assign col_c = CMP_W'(req.col_index);

  assign in_store = (row_c < DIM_MAX) && (col_c < DIM_MAX);
  assign in_dims  = (row_c < m_eff) && (col_c < n_eff);
  assign is_read  = (req.req_type == smm_pkg::REQ_READ_Y);

  assign req.ready = !queue_full;
  // Drop loads that fall outside the store; every read goes on.
  assign push      = req.valid && !queue_full && (is_read || in_store);

  assign push_cmd.req_type = req.req_type;
  assign push_cmd.row      = req.row_index;
  assign push_cmd.col      = req.col_index;
  assign push_cmd.value    = req.elem_value;
  assign push_cmd.ok       = is_read ? in_dims : in_store;

endmodule

// ===== src/smm_queue.sv =====
// Short command queue between the front end and the compute back end.
module smm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smm_pkg::cmd_t push_cmd,
  input  logic          pop,
  output smm_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(smm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(smm_pkg::QUEUE_DEPTH + 1);

  smm_pkg::cmd_t    entries [smm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(smm_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/smm_back.sv =====
// Back end: A/B/C stores, dot-product sequencer, scaling, saturation, result register.
module smm_back #(
  parameter int MAX_DIM = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  smm_pkg::cfg_t cfg_q,
  input  smm_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  smm_rsp_if.source     rsp
);

  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int KCNT_W    = $clog2(MAX_DIM + 1);
  localparam int CMP_W     = (KCNT_W > smm_pkg::DIM_REG_W) ? KCNT_W : smm_pkg::DIM_REG_W;
  localparam int PROD_W    = 2 * smm_pkg::ELEM_W;
  localparam int ACC_W     = PROD_W + KCNT_W;
  localparam int SCL_W     = ACC_W + smm_pkg::ELEM_W;
  localparam int SH_W      = SCL_W - 8;
  localparam int SUM_W     = (SH_W + 1 > smm_pkg::Y_W + 1) ? SH_W + 1 : smm_pkg::Y_W + 1;
  localparam int YW        = smm_pkg::Y_W;
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_FINAL = 3'd4;

  logic [2:0] state;
  logic       v1;
  logic       v2;
  logic       out_valid;
  logic       out_free;

  logic signed [smm_pkg::ELEM_W-1:0] a_mem [MEM_DEPTH];
  logic signed [smm_pkg::ELEM_W-1:0] b_mem [MEM_DEPTH];
  logic signed [smm_pkg::ELEM_W-1:0] c_mem [MEM_DEPTH];
  logic signed [smm_pkg::ELEM_W-1:0] a_rd;
  logic signed [smm_pkg::ELEM_W-1:0] b_rd;
  logic signed [smm_pkg::ELEM_W-1:0] c_rd;

  logic [ADDR_W-1:0] w_addr;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [ADDR_W-1:0] c_addr;
  logic              is_read;

  logic [smm_pkg::FIELD_IDX_W-1:0] row_reg;
  logic [smm_pkg::FIELD_IDX_W-1:0] col_reg;
  logic                            ok_reg;
  logic [IDX_W-1:0]                i_idx;
  logic [IDX_W-1:0]                j_idx;
  logic [IDX_W-1:0]                k;
  logic [CMP_W-1:0]                kd_wide;
  logic [KCNT_W-1:0]               kd;
  logic                            k_last;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [PROD_W-1:0] bias_prod;
  logic signed [SH_W-1:0]   shifted;
  logic signed [SUM_W-1:0]  sum;
  logic                     pos_ovf;
  logic                     neg_ovf;
  logic signed [YW-1:0]     y_sat;

  logic signed [YW-1:0]            y_q;
  logic [smm_pkg::FIELD_IDX_W-1:0] row_q;
  logic [smm_pkg::FIELD_IDX_W-1:0] col_q;
  logic                            range_q;

  assign kd_wide = (CMP_W'(cfg_q.k_depth) > DIM_MAX) ? DIM_MAX : CMP_W'(cfg_q.k_depth);
  assign kd      = KCNT_W'(kd_wide);
  assign k_last  = (KCNT_W'(k) + KCNT_W'(1)) == kd;

  assign is_read = (head.req_type == smm_pkg::REQ_READ_Y);
  assign pop     = (state == ST_IDLE) && !empty;

  assign i_idx  = IDX_W'(row_reg);
  assign j_idx  = IDX_W'(col_reg);
  assign w_addr = {IDX_W'(head.row), IDX_W'(head.col)};
  assign a_addr = cfg_q.trans_a ? {k, i_idx} : {i_idx, k};
  assign b_addr = cfg_q.trans_b ? {j_idx, k} : {k, j_idx};
  assign c_addr = {i_idx, j_idx};

  always_ff @(posedge clk) begin
    if (pop && head.req_type == smm_pkg::REQ_LOAD_A) begin
      a_mem[w_addr] <= head.value;
    end
    a_rd <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (pop && head.req_type == smm_pkg::REQ_LOAD_B) begin
      b_mem[w_addr] <= head.value;
    end
    b_rd <= b_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (pop && head.req_type == smm_pkg::REQ_LOAD_C) begin
      c_mem[w_addr] <= head.value;
    end
    c_rd <= c_mem[c_addr];
  end

  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= (state == ST_RUN);
      v2 <= v1;
      if (state == ST_FINAL && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop && is_read) begin
            if (!head.ok) begin
              state <= ST_FINAL;
            end else if (kd == '0) begin
              state <= ST_DRAIN;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (k_last) begin
            state <= ST_DRAIN;
          end
        end
        // Wait for the read and multiply stages to empty into the accumulator.
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: state <= ST_FINAL;
        ST_FINAL: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_reg <= head.row;
      col_reg <= head.col;
      ok_reg  <= head.ok;
      k       <= '0;
    end else if (state == ST_RUN) begin
      k <= k + IDX_W'(1);
    end

    prod <= a_rd * b_rd;

    if (pop) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end

    if (state == ST_SCALE) begin
      scaled <= acc * cfg_q.alpha;
      if (cfg_q.bias_enable) begin
        bias_prod <= cfg_q.beta * c_rd;
      end else begin
        bias_prod <= '0;
      end
    end

    if (state == ST_FINAL && out_free) begin
      y_q     <= ok_reg ? y_sat : '0;
      row_q   <= row_reg;
      col_q   <= col_reg;
      range_q <= ok_reg;
    end
  end

  // Arithmetic shift floors toward minus infinity.
  assign shifted = SH_W'(scaled >>> 8);
  assign sum     = SUM_W'(shifted) + SUM_W'(bias_prod);
  assign pos_ovf = !sum[SUM_W-1] && (|sum[SUM_W-2:YW-1]);
  assign neg_ovf = sum[SUM_W-1] && !(&sum[SUM_W-2:YW-1]);

  always_comb begin
    if (pos_ovf) begin
      y_sat = {1'b0, {(YW-1){1'b1}}};
    end else if (neg_ovf) begin
      y_sat = {1'b1, {(YW-1){1'b0}}};
    end else begin
      y_sat = sum[YW-1:0];
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.y_value  = y_q;
  assign rsp.out_row  = row_q;
  assign rsp.out_col  = col_q;
  assign rsp.in_range = range_q;

endmodule
